// File: rtl/core/stq_pkg.sv
package stq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_IDS     = 16;
  localparam int AW          = $clog2(QUEUE_DEPTH);
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [63:0] due;
    logic [3:0]  ident;
    logic [31:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam logic [2:0] REG_TPS_ADDR = 3'd0;
  localparam logic [31:0] TPS_RESET   = 32'd10000000;

  // Logical list position to ring slot, relative to the head slot.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] pos);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, pos};
    if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
      s = s - (CW + 1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

// File: rtl/core/stq_ram.sv
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sorted_timer_queue.sv
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   cmd, item_id, context_req, wait_seconds
// out       output     out_valid/out_stall kind, status, found, out_id, out_context, last
// config    APB        psel/penable/pready ticks_per_second at byte address 0
//
// One transaction at a time; the ring memory port sets the pace of every sweep.
// Add: multiply, sum, a cancel sweep (only for a queued id), then an insert sweep.
// Remove: a cancel sweep when queued. Tick: one head read per expired entry plus one.
// A waiting result holds the sequencer only where it must hand over the next one.
// Reset clears time, count and queued flags; the ring memory needs no clearing.
module sorted_timer_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  item_id_i,
  input  logic [31:0] context_req_i,
  input  logic [31:0] wait_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [3:0]  out_id_o,
  output logic [31:0] out_context_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_MUL, S_ADD_SUM, S_CAN, S_INS_START, S_INS, S_INS_HEAD,
    S_T_RD, S_T_CHK, S_EMIT
  } state_e;

  state_e             state_q;
  logic [31:0]        tps_q;
  logic [63:0]        time_q;
  logic [CW-1:0]      count_q;
  logic [AW-1:0]      head_q;
  logic [NUM_IDS-1:0] flags_q;
  logic [3:0]         id_q;
  logic [31:0]        ctx_q;
  logic [31:0]        wait_q;
  logic               is_add_q;
  logic [63:0]        prod_q;
  logic [63:0]        new_due_q;
  logic [CW-1:0]      rd_l_q;
  logic               rd_more_q;
  logic               dv_q;
  logic [CW-1:0]      dl_q;
  logic               found_q;
  logic [1:0]         res_kind_q;
  logic [1:0]         res_status_q;
  logic               res_found_q;
  logic [3:0]         pend_id_q;
  logic [31:0]        pend_tag_q;
  logic               have_pend_q;
  logic               out_valid_q;
  logic [1:0]         kind_q;
  logic [1:0]         status_q;
  logic               found_out_q;
  logic [3:0]         out_id_q;
  logic [31:0]        out_context_q;
  logic               last_q;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  entry_t             ram_wdata, rd, new_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               accept, out_free, ins_move, can_hit, due_ok, can_end;
  logic [64:0]        sum;

  stq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd         = entry_t'(ram_rdata);
  assign new_entry  = '{due: new_due_q, ident: id_q, tag: ctx_q};
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign ins_move   = rd.due > new_due_q;
  assign can_hit    = rd.ident == id_q;
  assign due_ok     = (count_q != '0) && (rd.due <= time_q);
  assign can_end    = dv_q && (dl_q == count_q - CW'(1));
  assign sum        = {1'b0, time_q} + {1'b0, prod_q};

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = head_q;
    ram_raddr = head_q;
    ram_wdata = rd;
    unique case (state_q)
      S_CAN: begin
        ram_re    = rd_more_q;
        ram_raddr = phys(head_q, rd_l_q);
        ram_we    = dv_q && found_q;
        ram_waddr = phys(head_q, dl_q - CW'(1));
      end
      S_INS: begin
        ram_re    = rd_more_q;
        ram_raddr = phys(head_q, rd_l_q);
        ram_we    = dv_q;
        ram_waddr = phys(head_q, dl_q + CW'(1));
        ram_wdata = ins_move ? rd : new_entry;
      end
      S_INS_HEAD: begin
        ram_we    = 1'b1;
        ram_wdata = new_entry;
      end
      S_T_RD: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tps_q       <= TPS_RESET;
      time_q      <= '0;
      count_q     <= '0;
      head_q      <= '0;
      flags_q     <= '0;
      have_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      rd_more_q   <= 1'b0;
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_TPS_ADDR[2]) begin
        tps_q <= pwdata;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      dv_q <= rd_more_q;
      dl_q <= rd_l_q;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            id_q   <= item_id_i;
            ctx_q  <= context_req_i;
            wait_q <= wait_seconds_i;
            unique case (cmd_i)
              CMD_ADD: begin
                state_q <= S_ADD_MUL;
              end
              CMD_REMOVE: begin
                if (flags_q[item_id_i]) begin
                  is_add_q  <= 1'b0;
                  rd_l_q    <= '0;
                  rd_more_q <= 1'b1;
                  found_q   <= 1'b0;
                  state_q   <= S_CAN;
                end else begin
                  res_kind_q   <= KIND_REMOVE;
                  res_status_q <= ST_OK;
                  res_found_q  <= 1'b0;
                  state_q      <= S_EMIT;
                end
              end
              CMD_TICK: begin
                time_q  <= time_q + 64'd1;
                state_q <= S_T_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD_MUL: begin
          prod_q  <= {32'd0, wait_q} * {32'd0, tps_q};
          state_q <= S_ADD_SUM;
        end
        S_ADD_SUM: begin
          new_due_q    <= sum[63:0];
          res_kind_q   <= KIND_ADD;
          res_found_q  <= 1'b0;
          res_status_q <= ST_OK;
          if (sum[64]) begin
            res_status_q <= ST_OVERFLOW;
            state_q      <= S_EMIT;
          end else if (flags_q[id_q]) begin
            is_add_q  <= 1'b1;
            rd_l_q    <= '0;
            rd_more_q <= 1'b1;
            found_q   <= 1'b0;
            state_q   <= S_CAN;
          end else if (count_q >= CW'(QUEUE_DEPTH)) begin
            res_status_q <= ST_FULL;
            state_q      <= S_EMIT;
          end else begin
            state_q <= S_INS_START;
          end
        end
        S_CAN: begin
          if (rd_more_q) begin
            if (rd_l_q == count_q - CW'(1)) begin
              rd_more_q <= 1'b0;
            end else begin
              rd_l_q <= rd_l_q + CW'(1);
            end
          end
          if (dv_q && !found_q && can_hit) begin
            found_q <= 1'b1;
          end
          if (can_end) begin
            rd_more_q      <= 1'b0;
            count_q        <= count_q - CW'(1);
            flags_q[id_q]  <= 1'b0;
            if (is_add_q) begin
              state_q <= S_INS_START;
            end else begin
              res_kind_q   <= KIND_REMOVE;
              res_status_q <= ST_OK;
              res_found_q  <= 1'b1;
              state_q      <= S_EMIT;
            end
          end
        end
        S_INS_START: begin
          if (count_q == '0) begin
            state_q <= S_INS_HEAD;
          end else begin
            rd_l_q    <= count_q - CW'(1);
            rd_more_q <= 1'b1;
            state_q   <= S_INS;
          end
        end
        S_INS: begin
          if (rd_more_q) begin
            if (rd_l_q == '0) begin
              rd_more_q <= 1'b0;
            end else begin
              rd_l_q <= rd_l_q - CW'(1);
            end
          end
          if (dv_q) begin
            if (ins_move) begin
              if (dl_q == '0) begin
                rd_more_q <= 1'b0;
                state_q   <= S_INS_HEAD;
              end
            end else begin
              rd_more_q     <= 1'b0;
              count_q       <= count_q + CW'(1);
              flags_q[id_q] <= 1'b1;
              state_q       <= S_EMIT;
            end
          end
        end
        S_INS_HEAD: begin
          count_q       <= count_q + CW'(1);
          flags_q[id_q] <= 1'b1;
          state_q       <= S_EMIT;
        end
        S_T_RD: begin
          state_q <= S_T_CHK;
        end
        S_T_CHK: begin
          // An expired entry is held back until the next head is known, so that
          // the final one of the transaction can carry the last flag.
          if (due_ok) begin
            if (!have_pend_q || out_free) begin
              if (have_pend_q) begin
                out_valid_q   <= 1'b1;
                kind_q        <= KIND_EXPIRE;
                status_q      <= ST_OK;
                found_out_q   <= 1'b0;
                out_id_q      <= pend_id_q;
                out_context_q <= pend_tag_q;
                last_q        <= 1'b0;
              end
              have_pend_q        <= 1'b1;
              pend_id_q          <= rd.ident;
              pend_tag_q         <= rd.tag;
              flags_q[rd.ident]  <= 1'b0;
              count_q            <= count_q - CW'(1);
              head_q             <= phys(head_q, CW'(1));
              state_q            <= S_T_RD;
            end
          end else if (out_free) begin
            out_valid_q   <= 1'b1;
            kind_q        <= have_pend_q ? KIND_EXPIRE : KIND_NONE;
            status_q      <= ST_OK;
            found_out_q   <= 1'b0;
            out_id_q      <= have_pend_q ? pend_id_q : 4'd0;
            out_context_q <= have_pend_q ? pend_tag_q : 32'd0;
            last_q        <= 1'b1;
            have_pend_q   <= 1'b0;
            state_q       <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            kind_q        <= res_kind_q;
            status_q      <= res_status_q;
            found_out_q   <= res_found_q;
            out_id_q      <= id_q;
            out_context_q <= 32'd0;
            last_q        <= 1'b1;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign status_o      = status_q;
  assign found_o       = found_out_q;
  assign out_id_o      = out_id_q;
  assign out_context_o = out_context_q;
  assign last_o        = last_q;
  assign prdata        = tps_q;
  assign pready        = 1'b1;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(flags_q) == 32'(count_q)))
    else $error("queued flags disagree with entry count");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("memory written while idle");

endmodule
